@@ hw/rtl/gesolve_pkg.sv @@
// ----------------------------------------------------------------------------
// gesolve_pkg
// shared types and constants of the linear system solver
// ----------------------------------------------------------------------------
package gesolve_pkg;

    localparam int FRAC_BITS     = 32;
    localparam int SIZE_BITS     = 5;
    localparam int THRESH_BITS   = 47;
    localparam int CFG_DATA_BITS = 47;
    localparam int ROW_BITS      = 4;
    localparam int COL_BITS      = 5;
    localparam int INDEX_BITS    = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    localparam logic CFG_SIZE   = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_SINGULAR = 1'b1;

    localparam int SIZE_RESET   = 16;
    localparam int THRESH_RESET = 1;

    typedef enum logic [5:0] {
        S_IDLE,
        S_COPY,
        S_PS_RD,
        S_PS_CMP,
        S_SW_RD1,
        S_SW_RD2,
        S_SW_WR1,
        S_SW_WR2,
        S_CHK,
        S_PV_GET,
        S_EL_RD,
        S_EL_F,
        S_EL_RD1,
        S_EL_M,
        S_EL_RD2,
        S_EL_WR,
        S_BS_RD,
        S_BS_X,
        S_BS_RA,
        S_BS_RX,
        S_BS_M,
        S_BS_SUB,
        S_BS_RP,
        S_BS_D,
        S_BS_WR,
        S_OUT_RD,
        S_OUT,
        S_SING,
        S_MUL,
        S_MUL_FIN,
        S_DIV,
        S_DIV_FIN
    } state_t;

endpackage

@@ hw/rtl/gesolve_ram.sv @@
// ----------------------------------------------------------------------------
// gesolve_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gesolve_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/gaussian_elimination_solver_unit.sv @@
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_unit
// dense A x = b solver, gaussian elimination with partial pivoting
// ----------------------------------------------------------------------------
// A write request (cmd 0) stores one element of A, or of b when col equals
// the size, and leaves busy low. b is held in a column of its own, so a
// change of size never mixes up A and b. A solve request (cmd 1) copies the
// stored system into a working ram (one entry a cycle over the whole ram),
// then eliminates and back substitutes through that ram with one shared
// multiplier (four partial products) and one bit-serial divider. A solve
// has about n cubed over 3 multiply and subtract steps, plus about n squared
// over 2 divisions; busy is high all the while.
// Results come out as one-cycle result_valid strobes, one every other cycle,
// and must be taken as they appear.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver_unit #(
    parameter int MAX_N      = 16,
    parameter int VALUE_BITS = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cmd,
    input  logic [gesolve_pkg::ROW_BITS-1:0]      row,
    input  logic [gesolve_pkg::COL_BITS-1:0]      col,
    input  logic signed [VALUE_BITS-1:0]          value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [gesolve_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output logic                                  result_valid,
    output logic [gesolve_pkg::INDEX_BITS-1:0]    index,
    output logic signed [VALUE_BITS-1:0]          solution,
    output logic                                  status,
    output logic                                  last
);

    import gesolve_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int RW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW    = $clog2(MAX_N + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int H     = (VB + 1) / 2;
    localparam int PW    = 2 * VB;
    localparam int MW    = PW + 1;
    localparam int NW    = VB + FRAC_BITS + 1;
    localparam int DCW   = $clog2(NW + 1);

    localparam logic [VB-1:0] MAXV = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0] MINV = {1'b1, {(VB-1){1'b0}}};

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [SIZE_BITS-1:0]   size_reg, size_next;
    logic [THRESH_BITS-1:0] thr_reg, thr_next;

    logic [AW:0]    cnt_reg, cnt_next;
    logic [CW-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0]  best_reg, best_next;
    logic [VB-1:0]  bestmag_reg, bestmag_next;
    logic [VB-1:0]  piv_reg, piv_next;
    logic [VB-1:0]  tmp_reg, tmp_next;
    logic [VB-1:0]  x_reg, x_next;

    logic [VB-1:0]  ma_reg, ma_next, mb_reg, mb_next;
    logic           mneg_reg, mneg_next;
    logic [2:0]     mcnt_reg, mcnt_next;
    logic [1:0]     pidx_reg, pidx_next;
    logic [2*H-1:0] prod_reg, prod_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [VB-1:0]  mul_res_reg, mul_res_next;

    logic [NW-1:0]  num_reg, num_next;
    logic [VB-1:0]  d_reg, d_next, r_reg, r_next, q_reg, q_next;
    logic           ovf_reg, ovf_next, dneg_reg, dneg_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [VB-1:0]  div_res_reg, div_res_next;

    logic                  rv_reg, rv_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [VB-1:0]         sol_reg, sol_next;
    logic                  st_reg, st_next, last_reg, last_next;

    logic [CW-1:0] n_eff, nm1;

    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [VB-1:0] s_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [VB-1:0] w_wdata, w_rdata;

    // column n addresses b, kept in column MAX_N
    function automatic logic [AW-1:0] adr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        adr = {r[RW-1:0], (c == n_eff) ? CW'(MAX_N) : c};
    endfunction

    function automatic logic [VB-1:0] mag(input logic [VB-1:0] a);
        mag = a[VB-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [VB-1:0] sat_mag(input logic neg, input logic [MW-1:0] m);
        logic [MW-1:0] lim;
        lim = (MW'(1) << (VB - 1)) - MW'(1);
        if (neg)
        begin
            sat_mag = (m > lim + MW'(1)) ? MINV : (~m[VB-1:0] + 1'b1);
        end
        else
        begin
            sat_mag = (m > lim) ? MAXV : m[VB-1:0];
        end
    endfunction

    function automatic logic [VB-1:0] sat_sub(input logic [VB-1:0] a, input logic [VB-1:0] b);
        logic [VB:0] diff;
        diff = {a[VB-1], a} - {b[VB-1], b};
        if (diff[VB] != diff[VB-1])
        begin
            sat_sub = diff[VB] ? MINV : MAXV;
        end
        else
        begin
            sat_sub = diff[VB-1:0];
        end
    endfunction

    gesolve_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (value),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    gesolve_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_work (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(size_reg) > MAX_N)
        begin
            n_eff = CW'(MAX_N);
        end
        else
        begin
            n_eff = CW'(size_reg);
        end
        nm1 = n_eff - CW'(1);
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = rv_reg;
    assign index        = idx_reg;
    assign solution     = sol_reg;
    assign status       = st_reg;
    assign last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            size_reg  <= SIZE_BITS'(SIZE_RESET);
            thr_reg   <= THRESH_BITS'(THRESH_RESET);
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            size_reg  <= size_next;
            thr_reg   <= thr_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        best_reg    <= best_next;
        bestmag_reg <= bestmag_next;
        piv_reg     <= piv_next;
        tmp_reg     <= tmp_next;
        x_reg       <= x_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        mneg_reg    <= mneg_next;
        mcnt_reg    <= mcnt_next;
        pidx_reg    <= pidx_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        mul_res_reg <= mul_res_next;
        num_reg     <= num_next;
        d_reg       <= d_next;
        r_reg       <= r_next;
        q_reg       <= q_next;
        ovf_reg     <= ovf_next;
        dneg_reg    <= dneg_next;
        dcnt_reg    <= dcnt_next;
        div_res_reg <= div_res_next;
        idx_reg     <= idx_next;
        sol_reg     <= sol_next;
        st_reg      <= st_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        logic [VB-1:0]  m;
        logic [CW-1:0]  bsel;
        logic [VB-1:0]  bmag;
        logic [VB:0]    rs;
        logic [H-1:0]   opa, opb;
        logic [PW-1:0]  addend;
        logic [PW:0]    rnd;

        state_next   = state_reg;
        ret_next     = ret_reg;
        size_next    = size_reg;
        thr_next     = thr_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        best_next    = best_reg;
        bestmag_next = bestmag_reg;
        piv_next     = piv_reg;
        tmp_next     = tmp_reg;
        x_next       = x_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        mneg_next    = mneg_reg;
        mcnt_next    = mcnt_reg;
        pidx_next    = pidx_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        mul_res_next = mul_res_reg;
        num_next     = num_reg;
        d_next       = d_reg;
        r_next       = r_reg;
        q_next       = q_reg;
        ovf_next     = ovf_reg;
        dneg_next    = dneg_reg;
        dcnt_next    = dcnt_reg;
        div_res_next = div_res_reg;
        rv_next      = 1'b0;
        idx_next     = idx_reg;
        sol_next     = sol_reg;
        st_next      = st_reg;
        last_next    = last_reg;

        s_we    = 1'b0;
        s_waddr = adr(CW'(row), CW'(col));
        s_raddr = cnt_reg[AW-1:0];
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = '0;

        m      = mag(w_rdata);
        bsel   = best_reg;
        bmag   = bestmag_reg;
        rs     = '0;
        opa    = '0;
        opb    = '0;
        addend = '0;
        rnd    = '0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIZE:   size_next = cfg_data[SIZE_BITS-1:0];
                CFG_THRESH: thr_next  = cfg_data[THRESH_BITS-1:0];
                default:    size_next = size_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_SOLVE)
                    begin
                        cnt_next   = '0;
                        state_next = S_COPY;
                    end
                    else if ((8'(row) < 8'(n_eff)) && (8'(col) <= 8'(n_eff)))
                    begin
                        s_we = 1'b1;
                    end
                end
            end

            // copy stored system into the working ram
            S_COPY:
            begin
                if (cnt_reg != '0)
                begin
                    w_we    = 1'b1;
                    w_waddr = AW'(cnt_reg - 1'b1);
                    w_wdata = s_rdata;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(DEPTH))
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_PS_RD;
                end
            end

            // pivot search
            S_PS_RD:
            begin
                w_raddr    = adr(k_reg, i_reg);
                state_next = S_PS_CMP;
            end

            S_PS_CMP:
            begin
                if ((k_reg == i_reg) || (m > bestmag_reg))
                begin
                    bsel = k_reg;
                    bmag = m;
                end
                best_next    = bsel;
                bestmag_next = bmag;
                if (k_reg == nm1)
                begin
                    j_next     = '0;
                    state_next = (bsel != i_reg) ? S_SW_RD1 : S_CHK;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_PS_RD;
                end
            end

            // row swap
            S_SW_RD1:
            begin
                w_raddr    = adr(i_reg, j_reg);
                state_next = S_SW_RD2;
            end

            S_SW_RD2:
            begin
                w_raddr    = adr(best_reg, j_reg);
                tmp_next   = w_rdata;
                state_next = S_SW_WR1;
            end

            S_SW_WR1:
            begin
                w_we       = 1'b1;
                w_waddr    = adr(i_reg, j_reg);
                w_wdata    = w_rdata;
                state_next = S_SW_WR2;
            end

            S_SW_WR2:
            begin
                w_we    = 1'b1;
                w_waddr = adr(best_reg, j_reg);
                w_wdata = tmp_reg;
                if (j_reg == n_eff)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SW_RD1;
                end
            end

            S_CHK:
            begin
                w_raddr = adr(i_reg, i_reg);
                if ((bestmag_reg == '0) || (64'(bestmag_reg) < 64'(thr_reg)))
                begin
                    state_next = S_SING;
                end
                else
                begin
                    state_next = S_PV_GET;
                end
            end

            S_PV_GET:
            begin
                piv_next = w_rdata;
                if (i_reg == nm1)
                begin
                    state_next = S_BS_RD;
                end
                else
                begin
                    k_next     = i_reg + 1'b1;
                    state_next = S_EL_RD;
                end
            end

            // elimination
            S_EL_RD:
            begin
                w_raddr    = adr(k_reg, i_reg);
                state_next = S_EL_F;
            end

            S_EL_F:
            begin
                dneg_next  = w_rdata[VB-1] ^ piv_reg[VB-1];
                d_next     = mag(piv_reg);
                num_next   = (NW'(mag(w_rdata)) << FRAC_BITS) + NW'(mag(piv_reg) >> 1);
                r_next     = '0;
                q_next     = '0;
                ovf_next   = 1'b0;
                dcnt_next  = '0;
                j_next     = i_reg;
                ret_next   = S_EL_RD1;
                state_next = S_DIV;
            end

            S_EL_RD1:
            begin
                w_raddr    = adr(i_reg, j_reg);
                state_next = S_EL_M;
            end

            S_EL_M:
            begin
                ma_next    = mag(div_res_reg);
                mb_next    = m;
                mneg_next  = div_res_reg[VB-1] ^ w_rdata[VB-1];
                mcnt_next  = '0;
                acc_next   = '0;
                ret_next   = S_EL_RD2;
                state_next = S_MUL;
            end

            S_EL_RD2:
            begin
                w_raddr    = adr(k_reg, j_reg);
                state_next = S_EL_WR;
            end

            S_EL_WR:
            begin
                w_we    = 1'b1;
                w_waddr = adr(k_reg, j_reg);
                w_wdata = sat_sub(w_rdata, mul_res_reg);
                if (j_reg == n_eff)
                begin
                    if (k_reg == nm1)
                    begin
                        i_next     = i_reg + 1'b1;
                        k_next     = i_reg + 1'b1;
                        state_next = S_PS_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_EL_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_EL_RD1;
                end
            end

            // back substitution, solution kept in the rhs column
            S_BS_RD:
            begin
                w_raddr    = adr(i_reg, n_eff);
                state_next = S_BS_X;
            end

            S_BS_X:
            begin
                x_next     = w_rdata;
                j_next     = i_reg + 1'b1;
                state_next = (i_reg == nm1) ? S_BS_RP : S_BS_RA;
            end

            S_BS_RA:
            begin
                w_raddr    = adr(i_reg, j_reg);
                state_next = S_BS_RX;
            end

            S_BS_RX:
            begin
                tmp_next   = w_rdata;
                w_raddr    = adr(j_reg, n_eff);
                state_next = S_BS_M;
            end

            S_BS_M:
            begin
                ma_next    = mag(tmp_reg);
                mb_next    = m;
                mneg_next  = tmp_reg[VB-1] ^ w_rdata[VB-1];
                mcnt_next  = '0;
                acc_next   = '0;
                ret_next   = S_BS_SUB;
                state_next = S_MUL;
            end

            S_BS_SUB:
            begin
                x_next = sat_sub(x_reg, mul_res_reg);
                if (j_reg == nm1)
                begin
                    state_next = S_BS_RP;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_BS_RA;
                end
            end

            S_BS_RP:
            begin
                w_raddr    = adr(i_reg, i_reg);
                state_next = S_BS_D;
            end

            S_BS_D:
            begin
                dneg_next  = x_reg[VB-1] ^ w_rdata[VB-1];
                d_next     = m;
                num_next   = (NW'(mag(x_reg)) << FRAC_BITS) + NW'(m >> 1);
                r_next     = '0;
                q_next     = '0;
                ovf_next   = 1'b0;
                dcnt_next  = '0;
                ret_next   = S_BS_WR;
                state_next = S_DIV;
            end

            S_BS_WR:
            begin
                w_we    = 1'b1;
                w_waddr = adr(i_reg, n_eff);
                w_wdata = div_res_reg;
                if (i_reg == '0)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = S_BS_RD;
                end
            end

            // result delivery
            S_OUT_RD:
            begin
                w_raddr    = adr(i_reg, n_eff);
                state_next = S_OUT;
            end

            S_OUT:
            begin
                rv_next   = 1'b1;
                idx_next  = INDEX_BITS'(i_reg);
                sol_next  = w_rdata;
                st_next   = STATUS_OK;
                last_next = (i_reg == nm1);
                if (i_reg == nm1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_OUT_RD;
                end
            end

            S_SING:
            begin
                rv_next    = 1'b1;
                idx_next   = '0;
                sol_next   = '0;
                st_next    = STATUS_SINGULAR;
                last_next  = 1'b1;
                state_next = S_IDLE;
            end

            // shared multiplier, one partial product a cycle
            S_MUL:
            begin
                unique case (mcnt_reg[1:0])
                    2'd0:
                    begin
                        opa = H'(ma_reg[H-1:0]);
                        opb = H'(mb_reg[H-1:0]);
                    end
                    2'd1:
                    begin
                        opa = H'(ma_reg[H-1:0]);
                        opb = H'(mb_reg >> H);
                    end
                    2'd2:
                    begin
                        opa = H'(ma_reg >> H);
                        opb = H'(mb_reg[H-1:0]);
                    end
                    default:
                    begin
                        opa = H'(ma_reg >> H);
                        opb = H'(mb_reg >> H);
                    end
                endcase
                prod_next = (2*H)'(opa) * (2*H)'(opb);
                pidx_next = mcnt_reg[1:0];
                unique case (pidx_reg)
                    2'd0:    addend = PW'(prod_reg);
                    2'd3:    addend = PW'(prod_reg) << (2 * H);
                    default: addend = PW'(prod_reg) << H;
                endcase
                if (mcnt_reg != '0)
                begin
                    acc_next = acc_reg + addend;
                end
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 3'd4)
                begin
                    state_next = S_MUL_FIN;
                end
            end

            S_MUL_FIN:
            begin
                rnd          = (PW+1)'(acc_reg) + ((PW+1)'(1) << (FRAC_BITS - 1));
                mul_res_next = sat_mag(mneg_reg, MW'(rnd >> FRAC_BITS));
                state_next   = ret_reg;
            end

            // shared restoring divider, one quotient bit a cycle
            S_DIV:
            begin
                rs       = {r_reg, num_reg[NW-1]};
                num_next = num_reg << 1;
                if (rs >= {1'b0, d_reg})
                begin
                    r_next = VB'(rs - {1'b0, d_reg});
                    q_next = {q_reg[VB-2:0], 1'b1};
                end
                else
                begin
                    r_next = rs[VB-1:0];
                    q_next = {q_reg[VB-2:0], 1'b0};
                end
                ovf_next  = ovf_reg | q_reg[VB-1];
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(NW - 1))
                begin
                    state_next = S_DIV_FIN;
                end
            end

            S_DIV_FIN:
            begin
                if (d_reg == '0)
                begin
                    div_res_next = '0;
                end
                else
                begin
                    div_res_next = sat_mag(dneg_reg, MW'({ovf_reg, q_reg}));
                end
                state_next = ret_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ tb/gaussian_elimination_solver_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_check
// Watches the request, register and result channels of the solver. It keeps
// its own copy of the stores and registers, and on every solve request it
// predicts the results: partial pivoting elimination and back substitution
// in saturating Q16.32. Each result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver_check #(
    parameter int MAX_N      = 16,
    parameter int VALUE_BITS = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic                                  cmd,
    input  logic [gesolve_pkg::ROW_BITS-1:0]      row,
    input  logic [gesolve_pkg::COL_BITS-1:0]      col,
    input  logic signed [VALUE_BITS-1:0]          value,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [gesolve_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                                  result_valid,
    input  logic [gesolve_pkg::INDEX_BITS-1:0]    index,
    input  logic signed [VALUE_BITS-1:0]          solution,
    input  logic                                  status,
    input  logic                                  last,
    output int                                    fails,
    output int                                    pending
);

    import gesolve_pkg::*;

    localparam longint VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    typedef struct {
        logic [INDEX_BITS-1:0] idx;
        longint                x;
        logic                  st;
        logic                  lst;
    } answer_t;

    longint               mat [MAX_N*MAX_N];
    longint               rhs [MAX_N];
    longint               xs  [MAX_N];
    logic [SIZE_BITS-1:0]   size_reg;
    logic [THRESH_BITS-1:0] thresh_reg;
    answer_t              answers [$];

    assign pending = answers.size();

    function automatic logic [63:0] mag_of(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint clamp_mag(logic neg, logic [127:0] m);
        if (neg)
        begin
            if (m > 128'(VMAX) + 1) return VMIN;
            return -longint'(m[63:0]);
        end
        if (m > 128'(VMAX)) return VMAX;
        return longint'(m[63:0]);
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        longint r;
        r = a - b;
        if (r > VMAX) return VMAX;
        if (r < VMIN) return VMIN;
        return r;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        p = 128'(mag_of(a)) * 128'(mag_of(b));
        p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return clamp_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        logic [127:0] nn;
        logic [127:0] d;
        d = 128'(mag_of(b));
        if (d == 0) return 0;
        nn = (128'(mag_of(a)) << FRAC_BITS) + (d >> 1);
        return clamp_mag((a < 0) != (b < 0), nn / d);
    endfunction

    function automatic int size_eff();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_N) return MAX_N;
        return int'(size_reg);
    endfunction

    task automatic predict_solve();
        longint      wa [MAX_N*MAX_N];
        longint      wb [MAX_N];
        int          n;
        int          best;
        longint      t;
        longint      f;
        longint      x;
        logic [63:0] pm;
        answer_t     a;
        n  = size_eff();
        wa = mat;
        wb = rhs;
        for (int i = 0; i < n; i++)
        begin
            best = i;
            for (int k = i + 1; k < n; k++)
                if (mag_of(wa[k*MAX_N+i]) > mag_of(wa[best*MAX_N+i])) best = k;
            if (best != i)
            begin
                for (int j = 0; j < n; j++)
                begin
                    t = wa[i*MAX_N+j];
                    wa[i*MAX_N+j] = wa[best*MAX_N+j];
                    wa[best*MAX_N+j] = t;
                end
                t = wb[i];
                wb[i] = wb[best];
                wb[best] = t;
            end
            pm = mag_of(wa[i*MAX_N+i]);
            if (pm == 0 || pm < 64'(thresh_reg))
            begin
                a.idx = '0;
                a.x   = 0;
                a.st  = STATUS_SINGULAR;
                a.lst = 1'b1;
                answers.push_back(a);
                return;
            end
            for (int k = i + 1; k < n; k++)
            begin
                f = fx_div(wa[k*MAX_N+i], wa[i*MAX_N+i]);
                for (int j = i; j < n; j++)
                    wa[k*MAX_N+j] = fx_sub(wa[k*MAX_N+j], fx_mul(f, wa[i*MAX_N+j]));
                wb[k] = fx_sub(wb[k], fx_mul(f, wb[i]));
            end
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            x = wb[i];
            for (int j = i + 1; j < n; j++)
                x = fx_sub(x, fx_mul(wa[i*MAX_N+j], xs[j]));
            xs[i] = fx_div(x, wa[i*MAX_N+i]);
        end
        for (int i = 0; i < n; i++)
        begin
            a.idx = INDEX_BITS'(i);
            a.x   = xs[i];
            a.st  = STATUS_OK;
            a.lst = (i == n - 1);
            answers.push_back(a);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t                a;
        logic [VALUE_BITS-1:0]  xe;
        int                     n;
        if (!rst_n)
        begin
            foreach (mat[i]) mat[i] = 0;
            foreach (rhs[i]) rhs[i] = 0;
            foreach (xs[i]) xs[i] = 0;
            size_reg   = SIZE_BITS'(SIZE_RESET);
            thresh_reg = THRESH_BITS'(THRESH_RESET);
            answers.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SIZE) size_reg = cfg_data[SIZE_BITS-1:0];
                else thresh_reg = cfg_data[THRESH_BITS-1:0];
            end
            if (start && !busy)
            begin
                n = size_eff();
                if (cmd == CMD_SOLVE)
                    predict_solve();
                else if (row < n && col <= n)
                begin
                    if (col == n) rhs[row] = longint'(value);
                    else mat[row*MAX_N+col] = longint'(value);
                end
            end
            if (result_valid)
            begin
                if (answers.size() == 0)
                begin
                    $error("result with nothing expected: index %0d solution %0d",
                           index, solution);
                    fails++;
                end
                else
                begin
                    a  = answers.pop_front();
                    xe = a.x[VALUE_BITS-1:0];
                    if (index !== a.idx)
                    begin
                        $error("index: expected %0d, got %0d", a.idx, index);
                        fails++;
                    end
                    if (solution !== xe)
                    begin
                        $error("solution: expected %0d, got %0d", $signed(xe), solution);
                        fails++;
                    end
                    if (status !== a.st)
                    begin
                        $error("status: expected %0d, got %0d", a.st, status);
                        fails++;
                    end
                    if (last !== a.lst)
                    begin
                        $error("last: expected %0d, got %0d", a.lst, last);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

@@ tb/gaussian_elimination_solver_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_unit_tb
// Loads systems of many sizes and solves them: a short directed part on the
// value extremes, pivot ties, zero and tiny pivots and ignored writes, then
// random loads and solves under changing size and threshold settings, with
// random gaps between requests. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver_unit_tb;
    import gesolve_pkg::*;

    localparam int     MAX_N      = 16;
    localparam int     VALUE_BITS = 48;
    localparam longint VMAX       = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
    localparam longint VMIN       = -VMAX - 1;
    localparam longint ONE        = 64'sd1 <<< FRAC_BITS;
    localparam longint CYCLE_CAP  = 6000000;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          cmd;
    logic [ROW_BITS-1:0]           row;
    logic [COL_BITS-1:0]           col;
    logic signed [VALUE_BITS-1:0]  value;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;
    logic                          result_valid;
    logic [INDEX_BITS-1:0]         index;
    logic signed [VALUE_BITS-1:0]  solution;
    logic                          status;
    logic                          last;
    int                            fails;
    int                            pending;

    longint cycles;
    int     size_now;
    int     idle_pct;
    int     sent;
    bit     mat_loaded [MAX_N*MAX_N];
    bit     rhs_loaded [MAX_N];

    gaussian_elimination_solver_unit #(.MAX_N(MAX_N), .VALUE_BITS(VALUE_BITS)) dut (.*);

    gaussian_elimination_solver_check #(.MAX_N(MAX_N), .VALUE_BITS(VALUE_BITS)) check (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint pick_value(bit diag);
        longint v;
        case ($urandom_range(0, 11))
            0: v = VMAX;
            1: v = VMIN;
            2: v = 0;
            3: v = longint'({$urandom, $urandom} << 16) >>> 16;
            default:
            begin
                v = longint'($urandom) << $urandom_range(0, 3);
                if ($urandom_range(0, 1)) v = -v;
                if (diag) v = v + 8 * ONE;
            end
        endcase
        return v;
    endfunction

    task automatic quiet();
        start <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send(logic c, int r, int k, longint v);
        bit free;
        while ($urandom_range(0, 99) < idle_pct) quiet();
        start <= 1'b1;
        cmd   <= c;
        row   <= ROW_BITS'(r);
        col   <= COL_BITS'(k);
        value <= VALUE_BITS'(v);
        do
        begin
            free = !busy;
            @(negedge clk);
        end
        while (!free);
        if (c == CMD_WRITE && r < size_now && k <= size_now)
        begin
            if (k == size_now) rhs_loaded[r] = 1'b1;
            else mat_loaded[r*MAX_N+k] = 1'b1;
        end
    endtask

    task automatic settle();
        quiet();
        while (pending != 0 || busy) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic set_reg(logic idx, longint data);
        bit took;
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(data);
        do
        begin
            took = cfg_ready;
            @(negedge clk);
        end
        while (!took);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == CFG_SIZE)
            size_now = (data[4:0] == 0) ? 1 : (data[4:0] > MAX_N) ? MAX_N : int'(data[4:0]);
    endtask

    task automatic load_system();
        bit need;
        for (int r = 0; r < size_now; r++)
            for (int k = 0; k <= size_now; k++)
            begin
                need = (k == size_now) ? !rhs_loaded[r] : !mat_loaded[r*MAX_N+k];
                if (need || $urandom_range(0, 2) == 0)
                begin
                    send(CMD_WRITE, r, k, pick_value(r == k));
                    sent++;
                end
                if ($urandom_range(0, 15) == 0)
                    send(CMD_WRITE, $urandom_range(0, 15), $urandom_range(size_now + 1, 31),
                         pick_value(0));
            end
    endtask

    task automatic random_round();
        longint th;
        set_reg(CFG_SIZE, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
        if ($urandom_range(0, 2) == 0)
        begin
            case ($urandom_range(0, 3))
                0: th = 0;
                1: th = 1;
                2: th = longint'($urandom) << $urandom_range(0, 3);
                default: th = (64'd1 << THRESH_BITS) - 1;
            endcase
            set_reg(CFG_THRESH, th);
        end
        repeat ($urandom_range(1, 3))
        begin
            load_system();
            send(CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 31), pick_value(0));
            sent++;
        end
    endtask

    initial
    begin
        cycles    = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = CMD_WRITE;
        row       = '0;
        col       = '0;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SIZE;
        cfg_data  = '0;
        size_now  = SIZE_RESET;
        idle_pct  = 18;
        sent      = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // size zero acts as one, right-hand side at the top of the range
        set_reg(CFG_SIZE, 0);
        send(CMD_WRITE, 0, 0, ONE);
        send(CMD_WRITE, 0, 1, VMAX);
        send(CMD_SOLVE, 0, 0, 0);
        // writes outside the system
        send(CMD_WRITE, 3, 0, VMIN);
        send(CMD_WRITE, 0, 5, VMAX);
        // pivot tie on magnitude, extreme entries, zero threshold
        set_reg(CFG_SIZE, 2);
        set_reg(CFG_THRESH, 0);
        send(CMD_WRITE, 0, 0, -2 * ONE);
        send(CMD_WRITE, 1, 0, 2 * ONE);
        send(CMD_WRITE, 0, 1, VMAX);
        send(CMD_WRITE, 1, 1, VMIN);
        send(CMD_WRITE, 0, 2, VMIN);
        send(CMD_WRITE, 1, 2, VMAX);
        send(CMD_SOLVE, 0, 0, 0);
        // zero pivot is singular even with a zero threshold
        send(CMD_WRITE, 0, 0, 0);
        send(CMD_WRITE, 1, 0, 0);
        send(CMD_SOLVE, 0, 0, 0);
        // largest threshold, pivots right at the limit
        send(CMD_WRITE, 0, 0, VMAX);
        set_reg(CFG_THRESH, (64'd1 << THRESH_BITS) - 1);
        send(CMD_SOLVE, 0, 0, 0);
        set_reg(CFG_THRESH, 1);

        // small systems, sender idles now and then
        while (sent < 30) random_round();

        // full size once, sender idles often
        idle_pct = 66;
        set_reg(CFG_THRESH, 1);
        set_reg(CFG_SIZE, $urandom_range(0, 1) ? 16 : $urandom_range(17, 31));
        load_system();
        send(CMD_SOLVE, 0, 0, 0);
        sent++;

        // small systems back to back
        idle_pct = 0;
        while (sent < 330) random_round();

        settle();
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
